// ===== rtl/mouse_motion_direction_events_macros.svh =====
// Assertion macros used by the checker file of the mouse direction block.
// Depends on nothing; include by bare file name.
`ifndef MOUSE_MOTION_DIRECTION_EVENTS_MACROS_SVH
`define MOUSE_MOTION_DIRECTION_EVENTS_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define MMDE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MMDE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/mmde_pkg.sv =====
// Types and constants for the mouse motion direction event block.
// Depends on nothing; imported by every module of the block.
package mmde_pkg;

    localparam int BUTTON_COUNT = 32;

    localparam int MOVE_THRESHOLD_RESET = 16;
    localparam int RELEASE_TICKS_RESET  = 100;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MOVE_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS  = 1'd1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        FUNC_MOTION   = 2'd0,
        FUNC_BTN_DOWN = 2'd1,
        FUNC_BTN_UP   = 2'd2,
        FUNC_TICK     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DIR    = 2'd1,
        KIND_BUTTON = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef struct packed {
        logic qualify;
        dir_t dir;
    } motion_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  code;
        logic        down;
        logic        second_valid;
        dir_t        second_dir;
    } evt_t;

endpackage

// ===== rtl/mmde_motion.sv =====
// Squared-distance test and four-way direction classifier for one motion.
// Depends on mmde_pkg.
module mmde_motion (
    input  logic [15:0]       stored_x,
    input  logic [15:0]       stored_y,
    input  logic [15:0]       pos_x,
    input  logic [15:0]       pos_y,
    input  logic [31:0]       move_threshold,
    output mmde_pkg::motion_t result
);
    import mmde_pkg::*;

    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] neg_dx;
    logic [16:0] neg_dy;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [31:0] sq_x;
    logic [31:0] sq_y;
    logic [32:0] mag;
    logic        dx_pos;
    logic        dy_pos;

    // differences are stored minus new position
    assign dx     = {1'b0, stored_x} - {1'b0, pos_x};
    assign dy     = {1'b0, stored_y} - {1'b0, pos_y};
    assign neg_dx = 17'd0 - dx;
    assign neg_dy = 17'd0 - dy;
    assign ax     = dx[16] ? neg_dx[15:0] : dx[15:0];
    assign ay     = dy[16] ? neg_dy[15:0] : dy[15:0];
    assign sq_x   = ax * ax;
    assign sq_y   = ay * ay;
    assign mag    = {1'b0, sq_x} + {1'b0, sq_y};
    assign dx_pos = !dx[16] && (dx != 17'd0);
    assign dy_pos = !dy[16] && (dy != 17'd0);

    always_comb begin
        result.qualify = (mag >= {1'b0, move_threshold});
        // ties go to the vertical axis
        if (ax > ay) begin
            result.dir = dx_pos ? DIR_W : DIR_E;
        end else begin
            result.dir = dy_pos ? DIR_N : DIR_S;
        end
    end

endmodule

// ===== rtl/mmde_tracker.sv =====
// Position, held-direction and idle-timer state with event decision logic.
// Depends on mmde_pkg and mmde_motion.
module mmde_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mmde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mmde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                advance,
    input  mmde_pkg::func_t                     func,
    input  logic [15:0]                         pos_x,
    input  logic [15:0]                         pos_y,
    input  logic [7:0]                          button,
    output mmde_pkg::evt_t                      evt
);
    import mmde_pkg::*;

    logic [31:0] move_threshold_reg;
    logic [15:0] release_ticks_reg;

    logic        have_pos_reg, have_pos_next;
    logic [15:0] stored_x_reg, stored_x_next;
    logic [15:0] stored_y_reg, stored_y_next;
    logic        dir_held_reg, dir_held_next;
    dir_t        held_dir_reg, held_dir_next;
    logic [15:0] idle_count_reg, idle_count_next;

    motion_t     motion;

    mmde_motion u_motion (
        .stored_x       (stored_x_reg),
        .stored_y       (stored_y_reg),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .move_threshold (move_threshold_reg),
        .result         (motion)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_threshold_reg <= 32'(MOVE_THRESHOLD_RESET);
            release_ticks_reg  <= 16'(RELEASE_TICKS_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MOVE_THRESHOLD: move_threshold_reg <= cfg_wdata;
                REG_RELEASE_TICKS:  release_ticks_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        have_pos_next   = have_pos_reg;
        stored_x_next   = stored_x_reg;
        stored_y_next   = stored_y_reg;
        dir_held_next   = dir_held_reg;
        held_dir_next   = held_dir_reg;
        idle_count_next = idle_count_reg;
        evt             = '0;
        case (func)
            FUNC_MOTION: begin
                if (!have_pos_reg) begin
                    // first motion only records the position
                    have_pos_next = 1'b1;
                    stored_x_next = pos_x;
                    stored_y_next = pos_y;
                end else if (motion.qualify) begin
                    if (!dir_held_reg) begin
                        evt.kind = KIND_DIR;
                        evt.code = 5'(motion.dir);
                        evt.down = 1'b1;
                    end else if (motion.dir != held_dir_reg) begin
                        evt.kind         = KIND_DIR;
                        evt.code         = 5'(held_dir_reg);
                        evt.second_valid = 1'b1;
                        evt.second_dir   = motion.dir;
                    end
                    stored_x_next   = pos_x;
                    stored_y_next   = pos_y;
                    dir_held_next   = 1'b1;
                    held_dir_next   = motion.dir;
                    idle_count_next = 16'd0;
                end
            end
            FUNC_BTN_DOWN, FUNC_BTN_UP: begin
                if (button < 8'(BUTTON_COUNT)) begin
                    evt.kind = KIND_BUTTON;
                    evt.code = button[4:0];
                    evt.down = (func == FUNC_BTN_DOWN);
                end
            end
            FUNC_TICK: begin
                if (dir_held_reg && (idle_count_reg >= release_ticks_reg)) begin
                    evt.kind      = KIND_DIR;
                    evt.code      = 5'(held_dir_reg);
                    dir_held_next = 1'b0;
                end else if (idle_count_reg != 16'hFFFF) begin
                    // saturate at full scale
                    idle_count_next = idle_count_reg + 16'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_pos_reg   <= 1'b0;
            stored_x_reg   <= 16'd0;
            stored_y_reg   <= 16'd0;
            dir_held_reg   <= 1'b0;
            held_dir_reg   <= DIR_N;
            idle_count_reg <= 16'd0;
        end else if (advance) begin
            have_pos_reg   <= have_pos_next;
            stored_x_reg   <= stored_x_next;
            stored_y_reg   <= stored_y_next;
            dir_held_reg   <= dir_held_next;
            held_dir_reg   <= held_dir_next;
            idle_count_reg <= idle_count_next;
        end
    end

endmodule

// ===== rtl/mouse_motion_direction_events.sv =====
// Top level of the mouse motion direction event block: input and result registers.
// Depends on mmde_pkg and mmde_tracker.
//
// Every input transaction yields exactly one result transaction. The block takes
// one item per clock cycle when the result side keeps up; an item passes through
// the input register and then the result register. The rate is set by the
// combinational state update in the tracker (two 16-bit squares, a 33-bit add
// and compare), which must finish before the next item is decided. Result kind
// 0 means no event; otherwise the result is a direction or button event, with
// an optional second direction press.
// Configuration writes are registered and take effect from the following cycle.
module mouse_motion_direction_events (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mmde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mmde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: pos_x[15:0], pos_y[31:16], button[39:32]
    input  logic [mmde_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: func[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: primary_code[4:0], primary_down[5], second_valid[6],
    //          second_dir[8:7], zero fill[15:9]
    output logic [mmde_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: primary_kind[1:0]
    output logic [1:0]                          m_tuser
);
    import mmde_pkg::*;

    logic        in_valid_reg;
    func_t       func_reg;
    logic [15:0] pos_x_reg;
    logic [15:0] pos_y_reg;
    logic [7:0]  button_reg;

    logic        out_valid_reg;
    evt_t        evt_reg;
    evt_t        evt;

    logic        s_accept;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg   <= func_t'(s_tuser);
            pos_x_reg  <= s_tdata[15:0];
            pos_y_reg  <= s_tdata[31:16];
            button_reg <= s_tdata[39:32];
        end
    end

    mmde_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .func      (func_reg),
        .pos_x     (pos_x_reg),
        .pos_y     (pos_y_reg),
        .button    (button_reg),
        .evt       (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            evt_reg <= evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = evt_reg.kind;
    assign m_tdata  = {7'd0, evt_reg.second_dir, evt_reg.second_valid,
                       evt_reg.down, evt_reg.code};

endmodule

// ===== rtl/mmde_checker.sv =====
// Port-level checker for the mouse motion direction event block, with its bind.
// Depends on mmde_pkg and mouse_motion_direction_events_macros.svh.
`include "mouse_motion_direction_events_macros.svh"

module mmde_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mmde_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [1:0]                       m_tuser
);
    import mmde_pkg::*;

    // hold a stalled result transaction
    `MMDE_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // no event means every field is zero
    `MMDE_ASSERT(a_none_clean, aclk, aresetn, m_tvalid && (m_tuser == KIND_NONE) |-> (m_tdata == '0), "empty result carries data")

    // a second press only follows a direction release to a different direction
    `MMDE_ASSERT(a_second_rel, aclk, aresetn, m_tvalid && m_tdata[6] |-> (m_tuser == KIND_DIR) && !m_tdata[5] && (m_tdata[4:2] == 3'd0) && (m_tdata[8:7] != m_tdata[1:0]), "bad direction change event")

    // a button event has no second press and no unknown kind is shown
    `MMDE_ASSERT(a_button_one, aclk, aresetn, m_tvalid && (m_tuser != KIND_NONE) && (m_tuser != KIND_DIR) |-> (m_tuser == KIND_BUTTON) && (m_tdata[8:6] == 3'd0), "bad button event")

    `MMDE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind mouse_motion_direction_events mmde_checker u_mmde_checker (.*);
